>>> rtl/lrs_pkg.sv
// ----------------------------------------------------------------------------
// lrs_pkg: shared types and constants of the lazy range-add / range-sum core
// Holds the node word layout, field widths, command codes and the defaults
// of the top-level parameters.
// ----------------------------------------------------------------------------
`default_nettype none

package lrs_pkg;

    localparam int POS_W  = 11;   // width of a position or range bound
    localparam int DATA_W = 64;   // width of sums, tags and deltas

    localparam int DEF_MAX_POSITIONS = 1024;
    localparam int DEF_NODE_COUNT    = 4096;

    localparam logic [POS_W-1:0] RESET_SIZE = POS_W'(1024);

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // One node of the tree: pending tag above, node sum below.
    typedef struct packed {
        logic [DATA_W-1:0] tag;
        logic [DATA_W-1:0] sum;
    } node_word_t;

    // Port of the node memory, driven by the sequencer.
    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        node_word_t wr_data;
    } mem_ctl_t;

endpackage

`default_nettype wire

>>> rtl/lrs_node_mem.sv
// ----------------------------------------------------------------------------
// lrs_node_mem: node memory of the segment tree
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_node_mem #(
    parameter int DEPTH = lrs_pkg::DEF_NODE_COUNT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic               clk,
    input  wire lrs_pkg::mem_ctl_t  ctl,
    input  wire logic [AW-1:0]      rd_addr,
    input  wire logic [AW-1:0]      wr_addr,
    output lrs_pkg::node_word_t     rd_data
);

    lrs_pkg::node_word_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= ctl.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/lazy_range_add_range_sum_core.sv
// ----------------------------------------------------------------------------
// lazy_range_add_range_sum_core: segment tree with lazy range add / range sum
// Walks the tree one node at a time with a frame stack, keeping node sums
// and pending tags in a single-port-read, single-port-write node memory.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | contents
//  --------+-----------+--------------------+-----------------------------------
//  s_      | in        | s_tvalid/s_tready  | tuser: command; tdata: range_low,
//          |           |                    |   range_high, delta
//  m_      | out       | m_tvalid/m_tready  | tdata: range_sum (queries only)
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_data: used_size
//
//  A command walks the tree depth first, one node visit after another. A
//  visit reads a covered or inner node in a memory read and write round (the
//  write only for an add on a covered node); a partly covered node then
//  pushes its tag to its children and, on an add, rebuilds its sum from them
//  on the way back. Each descent pushes a frame and each return pops it and
//  picks the next step; the pace is bound by the one read port of the node
//  memory. After reset the node memory is zeroed entry by entry; no request
//  is taken meanwhile. A finished sum waits in the output register while the
//  next request is taken; a query only stalls at its end if that slot is full.
// ----------------------------------------------------------------------------
`default_nettype none

module lazy_range_add_range_sum_core #(
    parameter int MAX_POSITIONS = lrs_pkg::DEF_MAX_POSITIONS,
    parameter int NODE_COUNT    = lrs_pkg::DEF_NODE_COUNT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [87:0]                s_tdata,   // range_low, range_high, delta, pad
    input  wire logic                       s_tuser,   // command
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [lrs_pkg::DATA_W-1:0]      m_tdata,   // range_sum
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [lrs_pkg::POS_W-1:0]  cfg_data   // used_size
);

    localparam int PW  = lrs_pkg::POS_W;
    localparam int DW  = lrs_pkg::DATA_W;
    localparam int AW  = $clog2(NODE_COUNT);
    localparam int KW  = AW + 1;                     // node index, room for overflow
    localparam int SD  = $clog2(MAX_POSITIONS) + 1;  // frames held above the current
    localparam int SPW = $clog2(SD + 1);
    localparam int IW  = $clog2(SD);

    typedef enum logic [1:0] {PH_ENTER, PH_LEFT_DONE, PH_RIGHT_DONE} phase_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_VISIT, S_COV, S_PUSH, S_APL_RD, S_APL_WR,
        S_DESC, S_CMB_A, S_CMB_B, S_CMB_C, S_POP, S_DONE
    } state_t;

    state_t              state_reg;
    logic [AW-1:0]       clr_cnt_reg;
    logic [PW-1:0]       used_size_reg;

    // request being worked on
    logic                query_reg;
    logic [PW-1:0]       lo_reg;
    logic [PW-1:0]       hi_reg;
    logic [DW-1:0]       delta_reg;
    logic [DW-1:0]       acc_reg;

    // current frame and the stack of its ancestors
    logic [KW-1:0]       cur_k_reg;
    logic [PW-1:0]       cur_l_reg;
    logic [PW-1:0]       cur_r_reg;
    phase_t              cur_ph_reg;
    logic [SPW-1:0]      sp_reg;
    logic [KW-1:0]       stk_k  [SD];
    logic [PW-1:0]       stk_l  [SD];
    logic [PW-1:0]       stk_r  [SD];
    phase_t              stk_ph [SD];

    logic [DW-1:0]       prod_reg;
    logic [DW-1:0]       tag_reg;
    logic [DW-1:0]       left_reg;
    logic                side_reg;
    logic                m_tvalid_reg;
    logic [DW-1:0]       m_tdata_reg;

    // memory interface
    lrs_pkg::mem_ctl_t   mem_ctl;
    logic [AW-1:0]       mem_raddr;
    logic [AW-1:0]       mem_waddr;
    lrs_pkg::node_word_t mem_rdata;

    lrs_node_mem #(
        .DEPTH (NODE_COUNT),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_addr (mem_raddr),
        .wr_addr (mem_waddr),
        .rd_data (mem_rdata)
    );

    // ------------------------------------------------------------------
    // Decode of the incoming request: clamp size and range.
    // ------------------------------------------------------------------
    logic [PW-1:0] in_lo;
    logic [PW-1:0] in_hi;
    logic [PW-1:0] eff_size;
    logic [PW-1:0] lo_clamped;
    logic [PW-1:0] hi_clamped;

    assign in_lo = s_tdata[PW-1:0];
    assign in_hi = s_tdata[2*PW-1:PW];

    always_comb
    begin
        if (used_size_reg == '0)
            eff_size = PW'(1);
        else if (32'(used_size_reg) > MAX_POSITIONS)
            eff_size = PW'(MAX_POSITIONS);
        else
            eff_size = used_size_reg;
        lo_clamped = (in_lo == '0) ? PW'(1) : in_lo;
        hi_clamped = (in_hi > eff_size) ? eff_size : in_hi;
    end

    // ------------------------------------------------------------------
    // Current node geometry.
    // ------------------------------------------------------------------
    logic [PW:0]   lr_sum;
    logic [PW-1:0] mid;
    logic [PW-1:0] len_cur;
    logic [PW-1:0] len_left;
    logic [PW-1:0] len_right;
    logic          beyond;
    logic          covered;
    logic          leaf;
    logic [KW-1:0] left_k;
    logic [KW-1:0] right_k;
    logic [KW-1:0] child_k;
    logic          left_ok;
    logic          right_ok;
    logic          child_ok;
    logic [IW-1:0] top_idx;
    logic [IW-1:0] push_idx;
    logic [SPW-1:0] sp_m1;

    assign lr_sum    = {1'b0, cur_l_reg} + {1'b0, cur_r_reg};
    assign mid       = lr_sum[PW:1];
    assign len_cur   = cur_r_reg - cur_l_reg + PW'(1);
    assign len_left  = mid - cur_l_reg + PW'(1);
    assign len_right = cur_r_reg - mid;
    assign beyond    = (32'(cur_k_reg) >= NODE_COUNT);
    assign covered   = (lo_reg <= cur_l_reg) && (cur_r_reg <= hi_reg);
    assign leaf      = (cur_l_reg >= cur_r_reg);
    assign left_k    = {cur_k_reg[KW-2:0], 1'b0};
    assign right_k   = {cur_k_reg[KW-2:0], 1'b1};
    assign child_k   = side_reg ? right_k : left_k;
    assign left_ok   = (32'(left_k)  < NODE_COUNT);
    assign right_ok  = (32'(right_k) < NODE_COUNT);
    assign child_ok  = (32'(child_k) < NODE_COUNT);
    assign sp_m1     = sp_reg - SPW'(1);
    assign top_idx   = sp_m1[IW-1:0];
    assign push_idx  = sp_reg[IW-1:0];

    // ------------------------------------------------------------------
    // Memory requests per state.
    // ------------------------------------------------------------------
    always_comb
    begin
        mem_ctl         = '0;
        mem_raddr       = cur_k_reg[AW-1:0];
        mem_waddr       = cur_k_reg[AW-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_ctl.wr_en = 1'b1;
                mem_waddr     = clr_cnt_reg;
            end
            S_VISIT:
            begin
                mem_ctl.rd_en = (cur_ph_reg == PH_ENTER) && !beyond && (covered || !leaf);
            end
            S_COV:
            begin
                mem_ctl.wr_en       = (query_reg == lrs_pkg::CMD_ADD);
                mem_ctl.wr_data.tag = mem_rdata.tag + delta_reg;
                mem_ctl.wr_data.sum = mem_rdata.sum + prod_reg;
            end
            S_PUSH:
            begin
                // clear the tag, keep the sum
                mem_ctl.wr_en       = (mem_rdata.tag != '0);
                mem_ctl.wr_data.sum = mem_rdata.sum;
            end
            S_APL_RD:
            begin
                mem_ctl.rd_en = child_ok;
                mem_raddr     = child_k[AW-1:0];
            end
            S_APL_WR:
            begin
                mem_ctl.wr_en       = 1'b1;
                mem_waddr           = child_k[AW-1:0];
                mem_ctl.wr_data.tag = mem_rdata.tag + tag_reg;
                mem_ctl.wr_data.sum = mem_rdata.sum + prod_reg;
            end
            S_CMB_A:
            begin
                mem_ctl.rd_en = left_ok;
                mem_raddr     = left_k[AW-1:0];
            end
            S_CMB_B:
            begin
                mem_ctl.rd_en = right_ok;
                mem_raddr     = right_k[AW-1:0];
            end
            S_CMB_C:
            begin
                // tag was cleared by the push before descending
                mem_ctl.wr_en       = 1'b1;
                mem_ctl.wr_data.sum = left_reg + (right_ok ? mem_rdata.sum : '0);
            end
            default:
            begin
                mem_ctl = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            used_size_reg <= lrs_pkg::RESET_SIZE;
            sp_reg        <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                used_size_reg <= cfg_data;
            end
            // drop the sum once taken, unless a new one is loaded this cycle
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (32'(clr_cnt_reg) == NODE_COUNT - 1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        query_reg  <= s_tuser;
                        lo_reg     <= lo_clamped;
                        hi_reg     <= hi_clamped;
                        delta_reg  <= s_tdata[2*PW+DW-1:2*PW];
                        acc_reg    <= '0;
                        cur_k_reg  <= KW'(1);
                        cur_l_reg  <= PW'(1);
                        cur_r_reg  <= eff_size;
                        cur_ph_reg <= PH_ENTER;
                        sp_reg     <= '0;
                        if (lo_clamped <= hi_clamped)
                            state_reg <= S_VISIT;
                        else if (s_tuser == lrs_pkg::CMD_QUERY)
                            state_reg <= S_DONE;
                    end
                end
                S_VISIT:
                begin
                    unique case (cur_ph_reg)
                        PH_ENTER:
                        begin
                            prod_reg <= delta_reg * len_cur;
                            priority if (beyond)
                                state_reg <= S_POP;
                            else if (covered)
                                state_reg <= S_COV;
                            else if (leaf)
                                state_reg <= S_POP;
                            else
                                state_reg <= S_PUSH;
                        end
                        PH_LEFT_DONE:
                        begin
                            if (hi_reg > mid)
                            begin
                                stk_k[push_idx]  <= cur_k_reg;
                                stk_l[push_idx]  <= cur_l_reg;
                                stk_r[push_idx]  <= cur_r_reg;
                                stk_ph[push_idx] <= PH_RIGHT_DONE;
                                sp_reg           <= sp_reg + SPW'(1);
                                cur_k_reg        <= right_k;
                                cur_l_reg        <= mid + PW'(1);
                                cur_ph_reg       <= PH_ENTER;
                            end
                            else
                            begin
                                state_reg <= (query_reg == lrs_pkg::CMD_QUERY) ? S_POP : S_CMB_A;
                            end
                        end
                        default:
                        begin
                            state_reg <= (query_reg == lrs_pkg::CMD_QUERY) ? S_POP : S_CMB_A;
                        end
                    endcase
                end
                S_COV:
                begin
                    if (query_reg == lrs_pkg::CMD_QUERY)
                        acc_reg <= acc_reg + mem_rdata.sum;
                    state_reg <= S_POP;
                end
                S_PUSH:
                begin
                    tag_reg  <= mem_rdata.tag;
                    side_reg <= 1'b0;
                    state_reg <= (mem_rdata.tag == '0) ? S_DESC : S_APL_RD;
                end
                S_APL_RD:
                begin
                    prod_reg <= tag_reg * (side_reg ? len_right : len_left);
                    if (child_ok)
                        state_reg <= S_APL_WR;
                    else if (!side_reg)
                        side_reg <= 1'b1;
                    else
                        state_reg <= S_DESC;
                end
                S_APL_WR:
                begin
                    if (!side_reg)
                    begin
                        side_reg  <= 1'b1;
                        state_reg <= S_APL_RD;
                    end
                    else
                    begin
                        state_reg <= S_DESC;
                    end
                end
                S_DESC:
                begin
                    stk_k[push_idx] <= cur_k_reg;
                    stk_l[push_idx] <= cur_l_reg;
                    stk_r[push_idx] <= cur_r_reg;
                    sp_reg          <= sp_reg + SPW'(1);
                    cur_ph_reg      <= PH_ENTER;
                    state_reg       <= S_VISIT;
                    if (lo_reg <= mid)
                    begin
                        stk_ph[push_idx] <= PH_LEFT_DONE;
                        cur_k_reg        <= left_k;
                        cur_r_reg        <= mid;
                    end
                    else
                    begin
                        stk_ph[push_idx] <= PH_RIGHT_DONE;
                        cur_k_reg        <= right_k;
                        cur_l_reg        <= mid + PW'(1);
                    end
                end
                S_CMB_A:
                begin
                    state_reg <= S_CMB_B;
                end
                S_CMB_B:
                begin
                    left_reg  <= left_ok ? mem_rdata.sum : '0;
                    state_reg <= S_CMB_C;
                end
                S_CMB_C:
                begin
                    state_reg <= S_POP;
                end
                S_POP:
                begin
                    if (sp_reg == '0)
                    begin
                        state_reg <= (query_reg == lrs_pkg::CMD_QUERY) ? S_DONE : S_IDLE;
                    end
                    else
                    begin
                        cur_k_reg  <= stk_k[top_idx];
                        cur_l_reg  <= stk_l[top_idx];
                        cur_r_reg  <= stk_r[top_idx];
                        cur_ph_reg <= stk_ph[top_idx];
                        sp_reg     <= sp_m1;
                        state_reg  <= S_VISIT;
                    end
                end
                S_DONE:
                begin
                    // hold until the output slot frees up
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= acc_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sp_reg) <= SD)
        else $error("frame stack overflow");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) |=> m_tvalid_reg)
        else $error("finished query sum not presented");

    a_push_after_visit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH) |-> $past(state_reg) == S_VISIT)
        else $error("tag push without a node read");

endmodule

`default_nettype wire
